FILE: hw/rtl/hsl_to_rgb_converter_assert.svh
// Assertion macros for the HSL to RGB converter checker.
// Needs nothing but a clock and, for the first macro, a reset.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Clocked check, switched off while reset is high.
`define HSL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds while reset is high.
`define HSL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/hsl2rgb_pkg.sv
// Shared constants and types of the HSL to RGB converter.
// No dependencies; every module of the converter imports it.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  // Hue arithmetic, in 1/16 degree
  localparam int HUE_SECTOR = 960;    // 60 degrees
  localparam int HUE_BIAS   = 34560;  // six full turns, lifts any 16-bit hue above zero
  localparam int HUE_SHIFT  = 26;
  localparam logic [16:0] HUE_RECIP = 17'(((64'd1 << HUE_SHIFT) + 64'd959) / 64'd960);

  // Sector count and a reciprocal for dividing a sector count up to 70 by six
  localparam int SECTORS = 6;
  localparam int SIX_SHIFT = 8;
  localparam logic [5:0] SIX_RECIP = 6'd43;

  // 960 = 15 * 64 and 1600 = 25 * 64
  localparam int SECTOR_SHIFT = 6;
  localparam int SECTOR_ODD   = 15;
  localparam int PCT_FULL  = 1600;
  localparam int PCT_SHIFT = 6;
  localparam int PCT_ODD   = 25;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

endpackage

FILE: hw/rtl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter.
// Instantiates hsl2rgb_front, hsl2rgb_chroma and hsl2rgb_mix; uses hsl2rgb_pkg.
`timescale 1ns / 1ps

// HSL to RGB color converter, one pixel per clock while nothing stalls.
//
// Input channel (hsl_valid / hsl_stall): hue in 1/16 degree (signed, any turn),
// saturation and lightness in 1/16 percent (clamped to 100 percent), alpha byte.
// A transfer happens on a rising edge with hsl_valid high and hsl_stall low.
// Output channel (rgb_valid / rgb_stall): 8-bit red, green, blue and the alpha
// byte, same transfer rule.
//
// Six register stages: stages A and B in the front end, C, D and E in the
// chroma stage and the output register in the mix stage. Throughput: one
// transfer per cycle while nothing stalls, set by the stage registers; no
// stage chains two wide multiplies (hue reciprocal, saturation and lightness
// scaling, chroma, weight, sector division).
//
// When the receiver holds rgb_stall, the output register holds its result;
// empty stages behind it keep filling, so hsl_stall rises only once all six
// stages hold an item. Reset (rst, synchronous) drops every valid bit; there
// is no state beyond the pipeline.
module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               hsl_valid,
  output logic               hsl_stall,
  input  logic signed [15:0] hue_sixteenths,
  input  logic [11:0]        saturation_sixteenths,
  input  logic [11:0]        lightness_sixteenths,
  input  logic [7:0]         alpha_in,
  output logic               rgb_valid,
  input  logic               rgb_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha_out
);
  import hsl2rgb_pkg::*;

  // front -> chroma
  logic                 front_ready;
  logic                 fc_valid;
  logic                 fc_ready;
  sector_t              fc_sector;
  logic [9:0]           fc_weight;
  logic [FRAC_BITS:0]   fc_sat;
  logic [FRAC_BITS:0]   fc_light;
  logic [FRAC_BITS:0]   fc_span;
  logic [7:0]           fc_alpha;

  // chroma -> mix
  logic                 cm_valid;
  logic                 cm_ready;
  sector_t              cm_sector;
  logic [FRAC_BITS:0]   cm_chroma;
  logic [FRAC_BITS:0]   cm_second;
  logic [FRAC_BITS:0]   cm_offset;
  logic [7:0]           cm_alpha;

  // stall is the inverse of the first stage's ready
  assign hsl_stall = !front_ready;

  hsl2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (hsl_valid),
    .in_ready   (front_ready),
    .hue        (hue_sixteenths),
    .sat        (saturation_sixteenths),
    .light      (lightness_sixteenths),
    .alpha      (alpha_in),
    .out_valid  (fc_valid),
    .out_ready  (fc_ready),
    .sector     (fc_sector),
    .weight     (fc_weight),
    .sat_unit   (fc_sat),
    .light_unit (fc_light),
    .span       (fc_span),
    .alpha_q    (fc_alpha)
  );

  hsl2rgb_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fc_valid),
    .in_ready   (fc_ready),
    .sector     (fc_sector),
    .weight     (fc_weight),
    .sat_unit   (fc_sat),
    .light_unit (fc_light),
    .span       (fc_span),
    .alpha      (fc_alpha),
    .out_valid  (cm_valid),
    .out_ready  (cm_ready),
    .sector_q   (cm_sector),
    .chroma_q   (cm_chroma),
    .second_q   (cm_second),
    .offset_q   (cm_offset),
    .alpha_q    (cm_alpha)
  );

  // output register lives in the mix stage; advance it whenever the receiver
  // is not stalling
  hsl2rgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cm_valid),
    .in_ready   (cm_ready),
    .sector     (cm_sector),
    .chroma     (cm_chroma),
    .second     (cm_second),
    .offset     (cm_offset),
    .alpha      (cm_alpha),
    .out_valid  (rgb_valid),
    .out_ready  (!rgb_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_q    (alpha_out)
  );

endmodule

FILE: hw/rtl/hsl2rgb_front.sv
// Front end: hue wrap into sector and weight, saturation and lightness to fixed point.
// Two register stages. Uses hsl2rgb_pkg.
`timescale 1ns / 1ps

module hsl2rgb_front #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    hue,
  input  logic [11:0]           sat,
  input  logic [11:0]           light,
  input  logic [7:0]            alpha,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsl2rgb_pkg::sector_t  sector,
  output logic [9:0]            weight,
  output logic [FRAC_BITS:0]    sat_unit,
  output logic [FRAC_BITS:0]    light_unit,
  output logic [FRAC_BITS:0]    span,
  output logic [7:0]            alpha_q
);
  import hsl2rgb_pkg::*;

  localparam int UNIT_W    = FRAC_BITS + 1;
  localparam int NUM_W     = FRAC_BITS + 5;
  localparam int DIV_SHIFT = NUM_W + 5;
  localparam int PROD_W    = 2 * NUM_W + 1;
  localparam logic [NUM_W:0] DIV_RECIP =
    (NUM_W + 1)'(((64'd1 << DIV_SHIFT) + 64'(PCT_ODD - 1)) / 64'(PCT_ODD));

  // stage A
  logic              a_valid;
  logic [16:0]       a_u;
  logic [33:0]       a_hue_prod;
  logic [PROD_W-1:0] a_sat_prod;
  logic [PROD_W-1:0] a_light_prod;
  logic [7:0]        a_alpha;
  logic              a_ready;
  logic              b_ready;

  logic signed [17:0] hue_biased;
  logic [16:0]        u_next;
  logic [10:0]        sat_clamp;
  logic [10:0]        light_clamp;
  logic [NUM_W-1:0]   sat_num;
  logic [NUM_W-1:0]   light_num;

  assign hue_biased  = 18'(hue) + 18'(HUE_BIAS);
  assign u_next      = hue_biased[16:0];
  assign sat_clamp   = (sat > 12'(PCT_FULL)) ? 11'(PCT_FULL) : sat[10:0];
  assign light_clamp = (light > 12'(PCT_FULL)) ? 11'(PCT_FULL) : light[10:0];
  assign sat_num     = NUM_W'(sat_clamp) << (FRAC_BITS - PCT_SHIFT);
  assign light_num   = NUM_W'(light_clamp) << (FRAC_BITS - PCT_SHIFT);

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_u          <= u_next;
      a_hue_prod   <= 34'(u_next) * 34'(HUE_RECIP);
      a_sat_prod   <= PROD_W'(sat_num) * PROD_W'(DIV_RECIP);
      a_light_prod <= PROD_W'(light_num) * PROD_W'(DIV_RECIP);
      a_alpha      <= alpha;
    end
  end

  // stage B
  logic [6:0]        turns6;
  logic [16:0]       rem_full;
  logic [9:0]        rem;
  logic [11:0]       six_prod;
  logic [3:0]        turns;
  logic [6:0]        sec_full;
  logic [9:0]        weight_next;
  logic [UNIT_W-1:0] sat_next;
  logic [UNIT_W-1:0] light_next;
  logic [UNIT_W:0]   light_dbl;
  logic [UNIT_W:0]   span_wide;

  assign turns6      = a_hue_prod[HUE_SHIFT +: 7];
  assign rem_full    = a_u - 17'(turns6) * 17'(HUE_SECTOR);
  assign rem         = rem_full[9:0];
  assign six_prod    = 12'(turns6) * 12'(SIX_RECIP);
  assign turns       = six_prod[SIX_SHIFT +: 4];
  assign sec_full    = turns6 - 7'(turns) * 7'(SECTORS);
  // odd sectors count the weight down, even ones up
  assign weight_next = turns6[0] ? (10'(HUE_SECTOR) - rem) : rem;
  assign sat_next    = a_sat_prod[DIV_SHIFT +: UNIT_W];
  assign light_next  = a_light_prod[DIV_SHIFT +: UNIT_W];
  assign light_dbl   = {light_next, 1'b0};
  assign span_wide   = (light_next[FRAC_BITS] || light_next[FRAC_BITS-1])
                     ? (((UNIT_W + 1)'(1) << UNIT_W) - light_dbl) : light_dbl;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      sector     <= sector_t'(sec_full[2:0]);
      weight     <= weight_next;
      sat_unit   <= sat_next;
      light_unit <= light_next;
      span       <= span_wide[UNIT_W-1:0];
      alpha_q    <= a_alpha;
    end
  end

endmodule

FILE: hw/rtl/hsl2rgb_chroma.sv
// Chroma, offset and secondary component, three register stages.
// Uses hsl2rgb_pkg.
`timescale 1ns / 1ps

module hsl2rgb_chroma #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsl2rgb_pkg::sector_t  sector,
  input  logic [9:0]            weight,
  input  logic [FRAC_BITS:0]    sat_unit,
  input  logic [FRAC_BITS:0]    light_unit,
  input  logic [FRAC_BITS:0]    span,
  input  logic [7:0]            alpha,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsl2rgb_pkg::sector_t  sector_q,
  output logic [FRAC_BITS:0]    chroma_q,
  output logic [FRAC_BITS:0]    second_q,
  output logic [FRAC_BITS:0]    offset_q,
  output logic [7:0]            alpha_q
);
  import hsl2rgb_pkg::*;

  localparam int UNIT_W = FRAC_BITS + 1;
  localparam int CP_W   = 2 * UNIT_W;
  localparam int XW_W   = UNIT_W + 10;
  localparam int XN_W   = XW_W - SECTOR_SHIFT;
  localparam int XK     = XN_W + 4;
  localparam int XP_W   = 2 * FRAC_BITS + 11;
  localparam logic [FRAC_BITS+5:0] X_RECIP =
    (FRAC_BITS + 6)'(((64'd1 << XK) + 64'(SECTOR_ODD - 1)) / 64'(SECTOR_ODD));

  logic c_ready;
  logic d_ready;
  logic e_ready;

  // stage C: span times saturation
  logic              c_valid;
  logic [CP_W-1:0]   c_prod;
  sector_t           c_sector;
  logic [9:0]        c_weight;
  logic [UNIT_W-1:0] c_light;
  logic [7:0]        c_alpha;

  // stage D: chroma times weight, offset
  logic              d_valid;
  logic [XW_W-1:0]   d_xw;
  logic [UNIT_W-1:0] d_chroma;
  logic [UNIT_W-1:0] d_offset;
  sector_t           d_sector;
  logic [7:0]        d_alpha;

  // stage E: divide by one sector width
  logic [XP_W-1:0]   x_prod;

  logic [UNIT_W-1:0] chroma_next;
  logic [XN_W-1:0]   xn;

  assign e_ready  = !out_valid || out_ready;
  assign d_ready  = !d_valid || e_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  assign chroma_next = c_prod[FRAC_BITS +: UNIT_W];
  assign xn          = d_xw[XW_W-1:SECTOR_SHIFT];
  assign second_q    = x_prod[XK +: UNIT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid <= in_valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
      if (e_ready) begin
        out_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_prod   <= CP_W'(span) * CP_W'(sat_unit);
      c_sector <= sector;
      c_weight <= weight;
      c_light  <= light_unit;
      c_alpha  <= alpha;
    end
    if (d_ready && c_valid) begin
      d_xw     <= XW_W'(chroma_next) * XW_W'(c_weight);
      d_chroma <= chroma_next;
      d_offset <= c_light - (chroma_next >> 1);
      d_sector <= c_sector;
      d_alpha  <= c_alpha;
    end
    if (e_ready && d_valid) begin
      x_prod   <= XP_W'(xn) * XP_W'(X_RECIP);
      chroma_q <= d_chroma;
      offset_q <= d_offset;
      sector_q <= d_sector;
      alpha_q  <= d_alpha;
    end
  end

endmodule

FILE: hw/rtl/hsl2rgb_mix.sv
// Sector routing, offset add, clamp and byte scaling into the output register.
// Uses hsl2rgb_pkg.
`timescale 1ns / 1ps

module hsl2rgb_mix #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsl2rgb_pkg::sector_t  sector,
  input  logic [FRAC_BITS:0]    chroma,
  input  logic [FRAC_BITS:0]    second,
  input  logic [FRAC_BITS:0]    offset,
  input  logic [7:0]            alpha,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic [7:0]            alpha_q
);
  import hsl2rgb_pkg::*;

  localparam int UNIT_W = FRAC_BITS + 1;

  function automatic logic [7:0] to_byte(input logic [UNIT_W:0] v);
    logic [UNIT_W:0]      clamped;
    logic [FRAC_BITS+9:0] scaled;
    clamped = (v > ((UNIT_W + 1)'(1) << FRAC_BITS)) ? ((UNIT_W + 1)'(1) << FRAC_BITS) : v;
    scaled  = ((FRAC_BITS + 10)'(clamped) << 8) - (FRAC_BITS + 10)'(clamped);
    return scaled[FRAC_BITS +: 8];
  endfunction

  logic [UNIT_W-1:0] r_comp;
  logic [UNIT_W-1:0] g_comp;
  logic [UNIT_W-1:0] b_comp;

  always_comb begin
    r_comp = '0;
    g_comp = '0;
    b_comp = '0;
    case (sector)
      SEC_RED_YELLOW: begin
        r_comp = chroma;
        g_comp = second;
      end
      SEC_YELLOW_GREEN: begin
        r_comp = second;
        g_comp = chroma;
      end
      SEC_GREEN_CYAN: begin
        g_comp = chroma;
        b_comp = second;
      end
      SEC_CYAN_BLUE: begin
        g_comp = second;
        b_comp = chroma;
      end
      SEC_BLUE_MAGENTA: begin
        r_comp = second;
        b_comp = chroma;
      end
      default: begin
        r_comp = chroma;
        b_comp = second;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      red     <= to_byte((UNIT_W + 1)'(r_comp) + (UNIT_W + 1)'(offset));
      green   <= to_byte((UNIT_W + 1)'(g_comp) + (UNIT_W + 1)'(offset));
      blue    <= to_byte((UNIT_W + 1)'(b_comp) + (UNIT_W + 1)'(offset));
      alpha_q <= alpha;
    end
  end

endmodule

FILE: hw/rtl/hsl2rgb_checker.sv
// Port-level checks of the HSL to RGB converter, bound to the top level.
// Uses the macros of hsl_to_rgb_converter_assert.svh.
`timescale 1ns / 1ps

`include "hsl_to_rgb_converter_assert.svh"

module hsl2rgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        hsl_valid,
  input logic        hsl_stall,
  input logic        rgb_valid,
  input logic        rgb_stall,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [7:0]  alpha_out
);

  logic quiet;

  // no input transfer and no output stall in this cycle
  assign quiet = !(hsl_valid && !hsl_stall) && !rgb_stall;

  `HSL_ASSERT_ALWAYS(a_reset_clears, clk, (rst |=> !rgb_valid), "output valid after reset")

  `HSL_ASSERT(a_hold_valid, clk, rst, ((rgb_valid && rgb_stall) |=> rgb_valid), "result dropped while stalled")

  `HSL_ASSERT(a_hold_data, clk, rst, ((rgb_valid && rgb_stall) |=> $stable({red, green, blue, alpha_out})), "result changed while stalled")

  `HSL_ASSERT(a_drains, clk, rst, ((quiet ##1 quiet ##1 quiet ##1 quiet ##1 quiet ##1 quiet ##1 quiet) |=> !rgb_valid), "pipeline did not drain")

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .hsl_valid (hsl_valid),
  .hsl_stall (hsl_stall),
  .rgb_valid (rgb_valid),
  .rgb_stall (rgb_stall),
  .red       (red),
  .green     (green),
  .blue      (blue),
  .alpha_out (alpha_out)
);
